// File: rtl/kce_pkg.sv
package kce_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_DIMS     = 8;
  localparam int COORD_BITS   = 16;

  localparam int P_W     = $clog2(MAX_POINTS);
  localparam int C_W     = $clog2(MAX_CLUSTERS);
  localparam int D_W     = $clog2(MAX_DIMS);
  localparam int PA_W    = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int CNT_W   = P_W + 1;
  localparam int SUM_W   = 32;
  localparam int SQ_W    = 2 * COORD_BITS + 2;
  localparam int DIST_W  = SQ_W + D_W;
  localparam int TOT_W   = PA_W + 2;

  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_NUM_POINTS   = 2'd1;
  localparam logic [1:0] REG_NUM_DIMS     = 2'd2;
  localparam logic [1:0] REG_MAX_PASSES   = 2'd3;

  typedef struct packed {
    logic [3:0]  num_clusters;
    logic [10:0] num_points;
    logic [3:0]  num_dims;
    logic [15:0] max_passes;
  } cfg_t;

  typedef enum logic [4:0] {
    S_LOAD, S_SEED_RD, S_SEED_WR,
    S_PT_START, S_D_RD, S_D_SQ, S_D_ACC, S_CMP, S_OWN,
    S_SUB_RD, S_SUB_WR, S_ADD_RD, S_ADD_WR, S_NEXT_PT,
    S_UPD_CHK, S_UPD_RD, S_DIV_GO, S_DIV_WAIT, S_UPD_WR, S_UPD_END,
    S_OUT_RD, S_OUT_SET, S_OUT_WAIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SEL_CUR, SEL_OLD, SEL_BEST
  } sum_sel_e;

  typedef struct packed {
    logic     load;
    logic     seed_wr;
    logic     pt_init;
    logic     sq;
    logic     acc;
    logic     cmp;
    logic     own;
    logic     wr_sub;
    logic     wr_add;
    logic     div_start;
    logic     upd_wr;
    logic     pass_end;
    logic     out_load;
    logic     j_inc;
    logic     j_clr;
    logic     c_inc;
    logic     c_clr;
    logic     p_inc;
    logic     p_clr;
    sum_sel_e sum_sel;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic j_last;
    logic c_last;
    logic p_last;
    logic skip;
    logic has_old;
    logic cnt_zero;
    logic div_done;
    logic again;
    logic out_taken;
  } sts_t;

endpackage

// File: rtl/kce_div.sv
module kce_div import kce_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic                    busy_o,
  output logic [COORD_BITS-1:0]   quot_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  mag_q, mag_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [CNT_W:0]    part;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [SUM_W-1:0]  res;

  always_comb begin
    part   = {rem_q, mag_q[SUM_W-1]};
    trial  = part - {1'b0, divisor_i};
    ge     = part >= {1'b0, divisor_i};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(SUM_W);
      neg_d  = dividend_i[SUM_W-1];
      mag_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? trial[CNT_W-1:0] : part[CNT_W-1:0];
      mag_d = {mag_q[SUM_W-2:0], ge};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign res    = neg_q ? (~mag_q + SUM_W'(1)) : mag_q;
  assign quot_o = res[COORD_BITS-1:0];
  assign busy_o = busy_q;

endmodule

// File: rtl/kce_dpath.sv
module kce_dpath import kce_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  input  logic signed [COORD_BITS-1:0] coord_value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] centroid_value_o,
  output logic [2:0]                   cluster_id_o,
  output logic [2:0]                   dim_index_o,
  output logic                         last_value_o,
  output logic [15:0]                  passes_used_o,
  output logic                         converged_o
);

  // clamped configuration
  logic [3:0]       kc, dc;
  logic [10:0]      nc;
  logic [15:0]      lc;
  logic [TOT_W-1:0] total;

  always_comb begin
    nc = (cfg_i.num_points < 11'd2) ? 11'd2 :
         (cfg_i.num_points > 11'(MAX_POINTS)) ? 11'(MAX_POINTS) : cfg_i.num_points;
    dc = (cfg_i.num_dims == 4'd0) ? 4'd1 :
         (cfg_i.num_dims > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : cfg_i.num_dims;
    kc = (cfg_i.num_clusters == 4'd0) ? 4'd1 :
         (cfg_i.num_clusters > 4'(MAX_CLUSTERS)) ? 4'(MAX_CLUSTERS) : cfg_i.num_clusters;
    if ({7'd0, kc} >= nc) begin
      kc = 4'(nc - 11'd1);
    end
    lc    = (cfg_i.max_passes == 16'd0) ? 16'd1 : cfg_i.max_passes;
    total = TOT_W'(nc) * TOT_W'(dc);
  end

  logic [3:0]       k_q, d_q;
  logic [10:0]      n_q;
  logic [15:0]      lim_q, pass_q;
  logic [PA_W-1:0]  li_q, pbase_q;
  logic [P_W-1:0]   pi_q;
  logic [C_W-1:0]   ci_q, best_q;
  logic [D_W-1:0]   ji_q;
  logic             changed_q;
  logic [DIST_W-1:0] acc_q, bestd_q;
  logic [SQ_W-1:0]  sq_q;
  logic [CNT_W-1:0] cnt_q [MAX_CLUSTERS];

  logic             load_last;
  logic             again;
  logic             j_last, c_last, p_last;

  assign load_last = ({2'd0, li_q} >= total) || ({2'd0, li_q} + TOT_W'(1) == total);
  assign j_last    = ({1'b0, ji_q} + 4'd1) == d_q;
  assign c_last    = ({1'b0, ci_q} + 4'd1) == k_q;
  assign p_last    = ({1'b0, pi_q} + 11'd1) == n_q;
  assign again     = changed_q && (({1'b0, pass_q} + 17'd1) < {1'b0, lim_q});

  // memories
  logic [COORD_BITS-1:0] pt_mem  [MAX_POINTS*MAX_DIMS];
  logic [COORD_BITS-1:0] cen_mem [MAX_CLUSTERS*MAX_DIMS];
  logic [SUM_W-1:0]      sum_mem [MAX_CLUSTERS*MAX_DIMS];
  logic [C_W-1:0]        own_mem [MAX_POINTS];

  logic [COORD_BITS-1:0] pt_rd_q, cen_rd_q;
  logic [SUM_W-1:0]      sum_rd_q;
  logic [C_W-1:0]        own_rd_q;
  logic [PA_W-1:0]       pt_addr;
  logic                  pt_we;
  logic [C_W-1:0]        sel_c;
  logic [C_W+D_W-1:0]    sum_addr, cen_addr;
  logic                  sum_we, cen_we;
  logic [SUM_W-1:0]      sum_wd, pt_ext;
  logic [COORD_BITS-1:0] cen_wd;
  logic [COORD_BITS-1:0] quot;
  logic                  div_busy;

  always_comb begin
    case (cmd_i.sum_sel)
      SEL_OLD:  sel_c = own_rd_q;
      SEL_BEST: sel_c = best_q;
      default:  sel_c = ci_q;
    endcase
  end

  assign pt_we    = cmd_i.load && ({2'd0, li_q} < total);
  assign pt_addr  = cmd_i.load ? li_q : (pbase_q + PA_W'(ji_q));
  assign pt_ext   = {{(SUM_W-COORD_BITS){pt_rd_q[COORD_BITS-1]}}, pt_rd_q};
  assign sum_addr = {sel_c, ji_q};
  assign cen_addr = {ci_q, ji_q};
  assign sum_we   = cmd_i.seed_wr || cmd_i.wr_sub || cmd_i.wr_add;
  assign sum_wd   = cmd_i.wr_sub ? (sum_rd_q - pt_ext) :
                    cmd_i.wr_add ? (sum_rd_q + pt_ext) : '0;
  assign cen_we   = cmd_i.seed_wr || (cmd_i.upd_wr && (quot != cen_rd_q));
  assign cen_wd   = cmd_i.seed_wr ? pt_rd_q : quot;

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_addr] <= coord_value_i;
    end
    pt_rd_q <= pt_mem[pt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wd;
    end
    sum_rd_q <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cen_we) begin
      cen_mem[cen_addr] <= cen_wd;
    end
    cen_rd_q <= cen_mem[cen_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.own) begin
      own_mem[pi_q] <= best_q;
    end
    own_rd_q <= own_mem[pi_q];
  end

  kce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_rd_q),
    .divisor_i  (cnt_q[sel_c]),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // distance arithmetic
  logic signed [COORD_BITS:0]     diff;
  logic signed [2*COORD_BITS+1:0] prod;

  assign diff = {pt_rd_q[COORD_BITS-1], pt_rd_q} - {cen_rd_q[COORD_BITS-1], cen_rd_q};
  assign prod = diff * diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      sq_q <= SQ_W'(prod);
    end
    if (cmd_i.pt_init || cmd_i.cmp) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_q + DIST_W'(sq_q);
    end
    if (cmd_i.cmp && ((ci_q == '0) || (acc_q < bestd_q))) begin
      bestd_q <= acc_q;
    end
  end

  logic load_go;
  assign load_go = cmd_i.load && load_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= 4'd2;
      n_q       <= 11'(MAX_POINTS);
      d_q       <= 4'd2;
      lim_q     <= 16'd100;
      li_q      <= '0;
      pbase_q   <= '0;
      pi_q      <= '0;
      ci_q      <= '0;
      ji_q      <= '0;
      best_q    <= '0;
      pass_q    <= '0;
      changed_q <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        k_q   <= kc;
        n_q   <= nc;
        d_q   <= dc;
        lim_q <= lc;
        if (load_last) begin
          li_q <= '0;
        end else begin
          li_q <= li_q + PA_W'(1);
        end
      end
      if (load_go) begin
        pass_q    <= '0;
        changed_q <= 1'b0;
        pi_q      <= '0;
        pbase_q   <= '0;
        ci_q      <= '0;
        ji_q      <= '0;
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          cnt_q[i] <= '0;
        end
      end
      if (cmd_i.j_clr) begin
        ji_q <= '0;
      end else if (cmd_i.j_inc) begin
        ji_q <= ji_q + D_W'(1);
      end
      if (cmd_i.c_clr) begin
        ci_q <= '0;
      end else if (cmd_i.c_inc) begin
        ci_q <= ci_q + C_W'(1);
      end
      if (cmd_i.p_clr) begin
        pi_q    <= '0;
        pbase_q <= '0;
      end else if (cmd_i.p_inc) begin
        pi_q    <= pi_q + P_W'(1);
        pbase_q <= pbase_q + PA_W'(d_q);
      end
      if (cmd_i.cmp && ((ci_q == '0) || (acc_q < bestd_q))) begin
        best_q <= ci_q;
      end
      if (cmd_i.wr_sub && j_last) begin
        cnt_q[sel_c] <= cnt_q[sel_c] - CNT_W'(1);
      end
      if (cmd_i.wr_add && j_last) begin
        cnt_q[sel_c] <= cnt_q[sel_c] + CNT_W'(1);
      end
      if (cen_we && cmd_i.upd_wr) begin
        changed_q <= 1'b1;
      end
      if (cmd_i.pass_end) begin
        pass_q <= pass_q + 16'd1;
        if (again) begin
          changed_q <= 1'b0;
        end
      end
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      centroid_value_o <= cen_rd_q;
      cluster_id_o     <= 3'(ci_q);
      dim_index_o      <= 3'(ji_q);
      last_value_o     <= c_last && j_last;
      passes_used_o    <= pass_q;
      converged_o      <= !changed_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.load_last = load_last;
    sts_o.j_last    = j_last;
    sts_o.c_last    = c_last;
    sts_o.p_last    = p_last;
    sts_o.has_old   = pass_q != 16'd0;
    sts_o.skip      = (pass_q != 16'd0) && (own_rd_q == best_q);
    sts_o.cnt_zero  = cnt_q[sel_c] == '0;
    sts_o.div_done  = !div_busy;
    sts_o.again     = again;
    sts_o.out_taken = out_valid_q && out_ready_i;
  end

endmodule

// File: rtl/kce_ctrl.sv
module kce_ctrl import kce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:     if (in_valid_i && sts_i.load_last) state_d = S_SEED_RD;
      S_SEED_RD:  state_d = S_SEED_WR;
      S_SEED_WR:  state_d = (sts_i.j_last && sts_i.c_last) ? S_PT_START : S_SEED_RD;
      S_PT_START: state_d = S_D_RD;
      S_D_RD:     state_d = S_D_SQ;
      S_D_SQ:     state_d = S_D_ACC;
      S_D_ACC:    state_d = sts_i.j_last ? S_CMP : S_D_RD;
      S_CMP:      state_d = sts_i.c_last ? S_OWN : S_D_RD;
      S_OWN:      state_d = sts_i.skip ? S_NEXT_PT : (sts_i.has_old ? S_SUB_RD : S_ADD_RD);
      S_SUB_RD:   state_d = S_SUB_WR;
      S_SUB_WR:   state_d = sts_i.j_last ? S_ADD_RD : S_SUB_RD;
      S_ADD_RD:   state_d = S_ADD_WR;
      S_ADD_WR:   state_d = sts_i.j_last ? S_NEXT_PT : S_ADD_RD;
      S_NEXT_PT:  state_d = sts_i.p_last ? S_UPD_CHK : S_PT_START;
      S_UPD_CHK: begin
        if (!sts_i.cnt_zero) state_d = S_UPD_RD;
        else if (sts_i.c_last) state_d = S_UPD_END;
      end
      S_UPD_RD:   state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: if (sts_i.div_done) state_d = S_UPD_WR;
      S_UPD_WR: begin
        if (!sts_i.j_last) state_d = S_UPD_RD;
        else state_d = sts_i.c_last ? S_UPD_END : S_UPD_CHK;
      end
      S_UPD_END:  state_d = sts_i.again ? S_PT_START : S_OUT_RD;
      S_OUT_RD:   state_d = S_OUT_SET;
      S_OUT_SET:  state_d = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (sts_i.out_taken) begin
          state_d = (sts_i.j_last && sts_i.c_last) ? S_LOAD : S_OUT_RD;
        end
      end
      default:    state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.sum_sel = SEL_CUR;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SEED_WR: begin
        cmd_o.seed_wr = 1'b1;
        if (sts_i.j_last) begin
          cmd_o.j_clr = 1'b1;
          cmd_o.c_clr = sts_i.c_last;
          cmd_o.p_clr = sts_i.c_last;
          cmd_o.c_inc = !sts_i.c_last;
          cmd_o.p_inc = !sts_i.c_last;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      S_PT_START: cmd_o.pt_init = 1'b1;
      S_D_SQ:     cmd_o.sq = 1'b1;
      S_D_ACC: begin
        cmd_o.acc   = 1'b1;
        cmd_o.j_inc = !sts_i.j_last;
      end
      S_CMP: begin
        cmd_o.cmp   = 1'b1;
        cmd_o.j_clr = 1'b1;
        cmd_o.c_clr = sts_i.c_last;
        cmd_o.c_inc = !sts_i.c_last;
      end
      S_SUB_RD:   cmd_o.sum_sel = SEL_OLD;
      S_SUB_WR: begin
        cmd_o.sum_sel = SEL_OLD;
        cmd_o.wr_sub  = 1'b1;
        cmd_o.j_clr   = sts_i.j_last;
        cmd_o.j_inc   = !sts_i.j_last;
      end
      S_ADD_RD:   cmd_o.sum_sel = SEL_BEST;
      S_ADD_WR: begin
        cmd_o.sum_sel = SEL_BEST;
        cmd_o.wr_add  = 1'b1;
        cmd_o.j_clr   = sts_i.j_last;
        cmd_o.j_inc   = !sts_i.j_last;
      end
      S_NEXT_PT: begin
        cmd_o.own   = 1'b1;
        cmd_o.p_clr = sts_i.p_last;
        cmd_o.p_inc = !sts_i.p_last;
      end
      S_UPD_CHK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.c_clr = sts_i.c_last;
          cmd_o.c_inc = !sts_i.c_last;
        end
      end
      S_DIV_GO:   cmd_o.div_start = 1'b1;
      S_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        if (sts_i.j_last) begin
          cmd_o.j_clr = 1'b1;
          cmd_o.c_clr = sts_i.c_last;
          cmd_o.c_inc = !sts_i.c_last;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      S_UPD_END:  cmd_o.pass_end = 1'b1;
      S_OUT_SET:  cmd_o.out_load = 1'b1;
      S_OUT_WAIT: begin
        if (sts_i.out_taken) begin
          if (sts_i.j_last) begin
            cmd_o.j_clr = 1'b1;
            cmd_o.c_clr = sts_i.c_last;
            cmd_o.c_inc = !sts_i.c_last;
          end else begin
            cmd_o.j_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/kmeans_clustering_engine.sv
// Lloyd k-means over signed Q8.8 points. Coordinates are taken one per cycle
// (points in order, dimensions within a point) into the point memory; the word
// that completes the data set starts the run and no further word is taken until
// every centroid coordinate has been delivered. A run seeds cluster c with point c,
// then each pass walks all points for the assignment, paced by the single-port
// point and centroid memories, and then updates the centroid of every non-empty
// cluster, paced by the bit-serial divider. Results come out in cluster-major
// order from an output register, one word at a time; the next word is read out
// only once the last has been taken.
module kmeans_clustering_engine import kce_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] coord_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] centroid_value_o,
  output logic [2:0]                   cluster_id_o,
  output logic [2:0]                   dim_index_o,
  output logic                         last_value_o,
  output logic [15:0]                  passes_used_o,
  output logic                         converged_o
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_clusters <= 4'd2;
      cfg_q.num_points   <= 11'd1024;
      cfg_q.num_dims     <= 4'd2;
      cfg_q.max_passes   <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NUM_CLUSTERS: cfg_q.num_clusters <= cfg_data_i[3:0];
        REG_NUM_POINTS:   cfg_q.num_points   <= cfg_data_i[10:0];
        REG_NUM_DIMS:     cfg_q.num_dims     <= cfg_data_i[3:0];
        REG_MAX_PASSES:   cfg_q.max_passes   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  kce_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .coord_value_i    (coord_value_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .centroid_value_o (centroid_value_o),
    .cluster_id_o     (cluster_id_o),
    .dim_index_o      (dim_index_o),
    .last_value_o     (last_value_o),
    .passes_used_o    (passes_used_o),
    .converged_o      (converged_o)
  );

  // no word is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");

  // the final word hands back to loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_value_o) |=> in_ready_o)
    else $error("no return to loading after final word");

  // every run makes at least one pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (passes_used_o != 16'd0))
    else $error("result without a pass");

endmodule
